>>> rtl/kch_pkg.sv
// Shared types and constants for the k-mer count histogram.
// Item payloads, command codes, table geometry and controller/datapath links.
// No dependencies.
package kch_pkg;

  localparam int MAX_K       = 8;
  localparam int COUNT_BITS  = 16;
  localparam int CODE_W      = 2 * MAX_K;
  localparam int FILL_W      = $clog2(MAX_K + 1);
  localparam int KLEN_W      = 4;
  localparam int TABLE_DEPTH = 1 << CODE_W;
  localparam int APB_AW      = 2;
  localparam int APB_DW      = 32;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [KLEN_W-1:0]     KLEN_RST  = KLEN_W'(4);
  localparam logic [APB_AW-3+1:0]   REG_KMER_LEN = '0;

  localparam logic [7:0] SYM_A = 8'h41;
  localparam logic [7:0] SYM_C = 8'h43;
  localparam logic [7:0] SYM_G = 8'h47;
  localparam logic [7:0] SYM_T = 8'h54;

  typedef enum logic [1:0] {
    CMD_PUSH    = 2'd0,
    CMD_READ    = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  symbol;
    logic [15:0] entry_index;
  } in_item_t;

  typedef struct packed {
    logic [15:0] count;
    logic        kmer_done;
    logic [15:0] kmer_code;
    logic        saturated;
  } out_item_t;

  typedef struct packed {
    logic clr_step;
    logic load_item;
    logic look;
    logic upd;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_full;
  } dp_stat_t;

endpackage

>>> rtl/kmer_count_histogram_top.sv
// Top level of the k-mer count histogram: APB register, controller, datapath.
// Depends on kch_pkg, kch_ctrl and kch_datapath.
//
// Usage:
//   in_valid/in_ready/in_data carry one command item: push a base byte, read
//   an entry, clear an entry or restart the window. out_valid/out_ready/
//   out_data return exactly one result item per command.
//   The APB port holds kmer_len at address 0 (reset 4); write it only while
//   the block is idle. pready is tied high.
// Timing:
//   out_valid rises after an accepted item has passed LOOK, UPD and PUT. A new
//   item is taken only once the last one has left PUT: the count table has one
//   read and one write port, and each item takes a read, a read-modify-write and an output load.
//   The output register lets the next item be accepted while a result waits.
// Reset:
//   rst_n clears the window and then sweeps all 65536 table entries to zero,
//   one per cycle; in_ready stays low until the sweep is done.
// Stall:
//   If out_ready stays low, the next finished result waits inside the block
//   and no further item is accepted until the output register frees.
module kmer_count_histogram_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  kch_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output kch_pkg::out_item_t          out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [kch_pkg::APB_AW-1:0]  paddr,
  input  logic [kch_pkg::APB_DW-1:0]  pwdata,
  output logic [kch_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import kch_pkg::*;

  logic [KLEN_W-1:0] kmer_len_r;
  logic [KLEN_W-1:0] k_eff;
  logic              reg_hit;
  dp_cmd_t           dp_cmd;
  dp_stat_t          dp_stat;

  assign pready  = 1'b1;
  assign reg_hit = (paddr == APB_AW'(4 * REG_KMER_LEN));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kmer_len_r <= KLEN_RST;
    end else if (psel && penable && pwrite && reg_hit) begin
      kmer_len_r <= pwdata[KLEN_W-1:0];
    end
  end

  assign prdata = reg_hit ? {{(APB_DW-KLEN_W){1'b0}}, kmer_len_r} : '0;

  always_comb begin
    priority if (kmer_len_r == '0) begin
      k_eff = KLEN_W'(1);
    end else if (kmer_len_r > KLEN_W'(MAX_K)) begin
      k_eff = KLEN_W'(MAX_K);
    end else begin
      k_eff = kmer_len_r;
    end
  end

  kch_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_ready(out_ready),
    .stat     (dp_stat),
    .cmd      (dp_cmd)
  );

  kch_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .k_eff    (k_eff),
    .in_data  (in_data),
    .cmd      (dp_cmd),
    .stat     (dp_stat),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .out_data (out_data)
  );

endmodule

>>> rtl/kch_ctrl.sv
// Controller FSM for the k-mer count histogram.
// Sequences the table clear sweep and the lookup/update/output steps of each item.
// Depends on kch_pkg.
module kch_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  input  kch_pkg::dp_stat_t stat,
  output kch_pkg::dp_cmd_t  cmd
);
  import kch_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_LOOK  = 5'b00100,
    S_UPD   = 5'b01000,
    S_PUT   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_PUT;
      end
      S_PUT: begin
        if (!stat.out_full || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

>>> rtl/kch_datapath.sv
// Datapath for the k-mer count histogram: window shift register, count table
// memory, saturating increment and the output register.
// Depends on kch_pkg.
module kch_datapath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [kch_pkg::KLEN_W-1:0] k_eff,
  input  kch_pkg::in_item_t         in_data,
  input  kch_pkg::dp_cmd_t          cmd,
  output kch_pkg::dp_stat_t         stat,
  input  logic                      out_ready,
  output logic                      out_valid,
  output kch_pkg::out_item_t        out_data
);
  import kch_pkg::*;

  logic [COUNT_BITS-1:0] count_mem [TABLE_DEPTH];

  in_item_t              item_r;
  logic [CODE_W-1:0]     code_r, code_nxt;
  logic [FILL_W-1:0]     fill_r, fill_nxt;
  logic [CODE_W-1:0]     addr_r, addr_nxt;
  logic                  counted_r, counted_nxt;
  logic [COUNT_BITS-1:0] rd_r;
  out_item_t             res_r, res_nxt;
  out_item_t             out_r;
  logic                  out_valid_r;
  logic [CODE_W-1:0]     clr_cnt_r;

  logic                  base_ok;
  logic [1:0]            base;
  logic [CODE_W-1:0]     shifted;
  logic [CODE_W-1:0]     kmask;
  logic [FILL_W-1:0]     fill_inc;
  logic [COUNT_BITS-1:0] inc_val;
  logic                  we;
  logic [CODE_W-1:0]     wa;
  logic [COUNT_BITS-1:0] wd;

  always_comb begin
    base_ok = 1'b1;
    base    = 2'd0;
    unique case (item_r.symbol)
      SYM_A:   base = 2'd0;
      SYM_C:   base = 2'd1;
      SYM_G:   base = 2'd2;
      SYM_T:   base = 2'd3;
      default: base_ok = 1'b0;
    endcase
  end

  always_comb begin
    shifted     = {code_r[CODE_W-3:0], base};
    kmask       = ~({CODE_W{1'b1}} << {k_eff, 1'b0});
    fill_inc    = (fill_r < FILL_W'(MAX_K)) ? fill_r + FILL_W'(1) : fill_r;
    code_nxt    = code_r;
    fill_nxt    = fill_r;
    counted_nxt = 1'b0;
    addr_nxt    = item_r.entry_index[CODE_W-1:0];
    if (item_r.cmd == CMD_PUSH) begin
      addr_nxt = shifted & kmask;
      if (base_ok) begin
        code_nxt    = shifted;
        fill_nxt    = fill_inc;
        counted_nxt = ({{(KLEN_W > FILL_W ? KLEN_W - FILL_W : 0){1'b0}}, fill_inc}
                       >= k_eff);
      end else begin
        code_nxt = '0;
        fill_nxt = '0;
      end
    end else if (item_r.cmd == CMD_RESTART) begin
      code_nxt = '0;
      fill_nxt = '0;
    end
  end

  always_comb begin
    inc_val = (rd_r < COUNT_MAX) ? rd_r + COUNT_BITS'(1) : rd_r;
    res_nxt = '0;
    unique case (item_r.cmd)
      CMD_PUSH: begin
        if (counted_r) begin
          res_nxt.count     = 16'(inc_val);
          res_nxt.kmer_done = 1'b1;
          res_nxt.kmer_code = 16'(addr_r);
          res_nxt.saturated = (inc_val == COUNT_MAX);
        end
      end
      CMD_READ: begin
        res_nxt.count     = 16'(rd_r);
        res_nxt.kmer_code = 16'(addr_r);
        res_nxt.saturated = (rd_r == COUNT_MAX);
      end
      CMD_CLEAR: begin
        res_nxt.kmer_code = 16'(addr_r);
      end
      default: begin
        res_nxt = '0;
      end
    endcase
  end

  assign we = cmd.clr_step
           | (cmd.upd & ((item_r.cmd == CMD_PUSH & counted_r) | item_r.cmd == CMD_CLEAR));
  assign wa = cmd.clr_step ? clr_cnt_r : addr_r;
  assign wd = (cmd.clr_step || item_r.cmd == CMD_CLEAR) ? '0 : inc_val;

  always_ff @(posedge clk) begin
    if (we) begin
      count_mem[wa] <= wd;
    end
    if (cmd.look) begin
      rd_r <= count_mem[addr_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_data;
    end
    if (cmd.look) begin
      addr_r    <= addr_nxt;
      counted_r <= counted_nxt;
    end
    if (cmd.upd) begin
      res_r <= res_nxt;
    end
    if (cmd.out_load) begin
      out_r <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r      <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      clr_cnt_r   <= '0;
    end else begin
      if (cmd.look) begin
        code_r <= code_nxt;
        fill_r <= fill_nxt;
      end
      if (cmd.clr_step) begin
        clr_cnt_r <= clr_cnt_r + CODE_W'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.clr_last = (clr_cnt_r == {CODE_W{1'b1}});
  assign stat.out_full = out_valid_r;
  assign out_valid     = out_valid_r;
  assign out_data      = out_r;

endmodule

>>> rtl/kch_checker.sv
// Port-level checks for the k-mer count histogram, bound to the top level.
// Depends on kch_pkg and kmer_count_histogram_top.
module kch_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input kch_pkg::out_item_t         out_data,
  input logic                       pready
);
  import kch_pkg::*;

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one item in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while another is in flight");

  a_done_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kmer_done |-> out_data.count != '0)
    else $error("counted k-mer reported with zero count");

  a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |-> out_data.count == 16'(COUNT_MAX))
    else $error("saturated flag without full count");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind kmer_count_histogram_top kch_checker u_kch_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data),
  .pready   (pready)
);

>>> tb/sv/kmer_count_histogram_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for kmer_count_histogram_top: directed table,
// random command phases over several k-mer lengths, idle and stall patterns.
// Depends on kch_pkg and kmer_count_histogram_top.
module kmer_count_histogram_top_tb;
  import kch_pkg::*;

  localparam int         CYCLE_LIMIT = 2_000_000;
  localparam int         HOLD_CYCLES = 400;
  localparam int         PHASE_ITEMS = 191;
  localparam logic [7:0] SYM_N       = 8'h4E;

  typedef struct {
    in_item_t  item;
    bit        lit;
    out_item_t want;
  } dir_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  // predictor state
  logic [KLEN_W-1:0]   klen_reg;
  logic [15:0]         win_code;
  int                  win_fill;
  logic [15:0]         tally [0:TABLE_DEPTH-1];
  logic [15:0]         last_code;
  out_item_t           pending_results[$];

  dir_row_t            tab[$];

  int fails;
  int cycle_cnt;
  int tx_idle_pct;
  int rx_stall_pct;
  int hold_req;
  int hold_seen;
  int hold_left;

  kmer_count_histogram_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic out_item_t tally_item(input in_item_t it);
    out_item_t   r;
    int          k;
    logic [15:0] mask;
    logic [15:0] kc;
    logic [15:0] v;
    logic [1:0]  b;
    bit          ok;
    r  = '0;
    b  = 2'd0;
    ok = 1'b1;
    if (klen_reg == 0) k = 1;
    else if (klen_reg > MAX_K) k = MAX_K;
    else k = klen_reg;
    mask = 16'((32'h1 << (2 * k)) - 1);
    case (it.cmd)
      CMD_PUSH: begin
        case (it.symbol)
          SYM_A:   b = 2'd0;
          SYM_C:   b = 2'd1;
          SYM_G:   b = 2'd2;
          SYM_T:   b = 2'd3;
          default: ok = 1'b0;
        endcase
        if (!ok) begin
          win_code = '0;
          win_fill = 0;
        end else begin
          win_code = {win_code[13:0], b};
          if (win_fill < MAX_K) win_fill++;
          if (win_fill >= k) begin
            kc = win_code & mask;
            v  = tally[kc];
            if (v != COUNT_MAX) v = v + 16'd1;
            tally[kc]   = v;
            r.count     = v;
            r.kmer_done = 1'b1;
            r.kmer_code = kc;
            r.saturated = (v == COUNT_MAX);
            last_code   = kc;
          end
        end
      end
      CMD_READ: begin
        v           = tally[it.entry_index];
        r.count     = v;
        r.kmer_code = it.entry_index;
        r.saturated = (v == COUNT_MAX);
      end
      CMD_CLEAR: begin
        tally[it.entry_index] = '0;
        r.kmer_code = it.entry_index;
      end
      default: begin
        win_code = '0;
        win_fill = 0;
      end
    endcase
    return r;
  endfunction

  function automatic dir_row_t mk_row(input cmd_t c, input logic [7:0] s, input logic [15:0] e,
                                      input bit l, input logic [15:0] cnt, input logic d,
                                      input logic [15:0] code, input logic sat);
    dir_row_t r;
    r.item.cmd         = c;
    r.item.symbol      = s;
    r.item.entry_index = e;
    r.lit              = l;
    r.want.count       = cnt;
    r.want.kmer_done   = d;
    r.want.kmer_code   = code;
    r.want.saturated   = sat;
    return r;
  endfunction

  function automatic void add_row(input cmd_t c, input logic [7:0] s, input logic [15:0] e,
                                  input bit l, input logic [15:0] cnt, input logic d,
                                  input logic [15:0] code, input logic sat);
    tab = {tab, mk_row(c, s, e, l, cnt, d, code, sat)};
  endfunction

  function automatic in_item_t gen_item();
    in_item_t it;
    int       r;
    it.cmd         = CMD_PUSH;
    it.symbol      = 8'($urandom_range(255));
    it.entry_index = 16'($urandom_range(65535));
    r = $urandom_range(99);
    if (r < 78) begin
      case ($urandom_range(3))
        0:       it.symbol = SYM_A;
        1:       it.symbol = SYM_C;
        2:       it.symbol = SYM_G;
        default: it.symbol = SYM_T;
      endcase
    end else if (r < 84) begin
      it.cmd = CMD_PUSH;
    end else if (r < 87) begin
      it.symbol = SYM_N;
    end else if (r < 93) begin
      it.cmd = CMD_READ;
      if ($urandom_range(1)) it.entry_index = last_code;
    end else if (r < 97) begin
      it.cmd = CMD_CLEAR;
      if ($urandom_range(1)) it.entry_index = last_code;
    end else begin
      it.cmd = CMD_RESTART;
    end
    return it;
  endfunction

  task automatic send_item(input in_item_t it, input bit lit, input out_item_t want);
    bit        taken;
    out_item_t pred;
    if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < tx_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = in_ready;
    end
    pred = tally_item(it);
    pending_results = {pending_results, (lit ? want : pred)};
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [KLEN_W-1:0] val);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(4 * REG_KMER_LEN);
    pwdata  <= APB_DW'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    klen_reg = val;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[KLEN_W-1:0] !== val) begin
      fails++;
      if (fails <= 10) $display("kmer_len readback: exp %h got %h", val, prdata[KLEN_W-1:0]);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_idle(input int mode);
    case (mode)
      0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      1:       begin tx_idle_pct = 62; rx_stall_pct = 0;  end
      2:       begin tx_idle_pct = 0;  rx_stall_pct = 62; end
      default: begin tx_idle_pct = 27; rx_stall_pct = 27; end
    endcase
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      fails++;
      if (fails <= 10) $display("result with nothing pending: %h", got);
    end else begin
      want = pending_results.pop_front();
      if (got.count !== want.count || got.kmer_done !== want.kmer_done ||
          got.kmer_code !== want.kmer_code || got.saturated !== want.saturated) begin
        fails++;
        if (fails <= 10)
          $display("mismatch: count %h/%h done %b/%b code %h/%h sat %b/%b (exp/got)",
                   want.count, got.count, want.kmer_done, got.kmer_done,
                   want.kmer_code, got.kmer_code, want.saturated, got.saturated);
      end
    end
  endtask

  always @(posedge clk) begin
    if (out_valid && out_ready) check_result(out_data);
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (rx_stall_pct > 0) begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    logic [KLEN_W-1:0] phase_k [8];
    int                p;
    int                i;
    phase_k = '{4'd8, 4'd15, 4'd0, 4'd2, 4'd3, 4'd6, 4'd7, 4'd4};
    fails        = 0;
    cycle_cnt    = 0;
    hold_req     = 0;
    hold_seen    = 0;
    hold_left    = 0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    klen_reg     = KLEN_RST;
    win_code     = '0;
    win_fill     = 0;
    last_code    = '0;
    for (i = 0; i < TABLE_DEPTH; i++) tally[i] = '0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;

    // k = 4 after reset
    add_row(CMD_READ,    8'h00, 16'h0000, 1, 16'h0000, 0, 16'h0000, 0);
    add_row(CMD_READ,    8'hFF, 16'hFFFF, 1, 16'h0000, 0, 16'hFFFF, 0);
    add_row(CMD_PUSH,    SYM_A, 16'hFFFF, 1, 16'h0000, 0, 16'h0000, 0);
    add_row(CMD_PUSH,    SYM_C, 16'h0000, 1, 16'h0000, 0, 16'h0000, 0);
    add_row(CMD_PUSH,    SYM_G, 16'h5555, 1, 16'h0000, 0, 16'h0000, 0);
    add_row(CMD_PUSH,    SYM_T, 16'hAAAA, 1, 16'h0001, 1, 16'h001B, 0);
    add_row(CMD_PUSH,    SYM_A, 16'h0000, 0, '0, 0, '0, 0);
    add_row(CMD_PUSH,    SYM_N, 16'h0000, 1, 16'h0000, 0, 16'h0000, 0);
    add_row(CMD_PUSH,    SYM_G, 16'h0000, 0, '0, 0, '0, 0);
    add_row(CMD_PUSH,    8'hFF, 16'h0000, 1, 16'h0000, 0, 16'h0000, 0);
    add_row(CMD_PUSH,    8'h00, 16'hFFFF, 1, 16'h0000, 0, 16'h0000, 0);
    add_row(CMD_PUSH,    8'h61, 16'h0000, 1, 16'h0000, 0, 16'h0000, 0);
    add_row(CMD_PUSH,    SYM_A, 16'h0000, 0, '0, 0, '0, 0);
    add_row(CMD_PUSH,    SYM_C, 16'h0000, 0, '0, 0, '0, 0);
    add_row(CMD_PUSH,    SYM_G, 16'h0000, 0, '0, 0, '0, 0);
    add_row(CMD_PUSH,    SYM_T, 16'h0000, 0, '0, 0, '0, 0);
    add_row(CMD_READ,    8'h00, 16'h001B, 0, '0, 0, '0, 0);
    add_row(CMD_CLEAR,   8'hA5, 16'h001B, 1, 16'h0000, 0, 16'h001B, 0);
    add_row(CMD_READ,    8'h5A, 16'h001B, 1, 16'h0000, 0, 16'h001B, 0);
    add_row(CMD_PUSH,    SYM_T, 16'h0000, 0, '0, 0, '0, 0);
    add_row(CMD_RESTART, 8'hFF, 16'hFFFF, 1, 16'h0000, 0, 16'h0000, 0);
    add_row(CMD_PUSH,    SYM_A, 16'h0000, 0, '0, 0, '0, 0);
    add_row(CMD_CLEAR,   8'h00, 16'hFFFF, 1, 16'h0000, 0, 16'hFFFF, 0);
    add_row(CMD_READ,    8'hFF, 16'h006C, 0, '0, 0, '0, 0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (tab[n]) send_item(tab[n].item, tab[n].lit, tab[n].want);

    for (p = 0; p < 8; p++) begin
      cfg_write(phase_k[p]);
      set_idle(p % 4);
      if (p == 0) hold_req++;
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2) drain();
        send_item(gen_item(), 0, '0);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
